// File: sv/hpq_pkg.sv
// Shared types, sizes and codes for the binary max-heap priority queue.
package hpq_pkg;

   // Heap storage geometry.
   localparam int DEPTH        = 64;
   localparam int IDX_W        = $clog2(DEPTH);
   localparam int CNT_W        = $clog2(DEPTH + 1);
   localparam int CHILD_W      = IDX_W + 2;
   localparam int PRIORITY_W   = 16;
   localparam int PAYLOAD_W    = 32;
   localparam int CAP_W        = 7;
   localparam int STATUS_W     = 2;
   localparam int OCC_W        = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   // Command codes.
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // Status codes.
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   // Request word.
   typedef struct packed {
      logic                  cmd;
      logic [PRIORITY_W-1:0] priority_req;
      logic [PAYLOAD_W-1:0]  payload;
   } req_type;

   // Response word.
   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [PRIORITY_W-1:0] out_priority;
      logic [PAYLOAD_W-1:0]  out_payload;
      logic [OCC_W-1:0]      occupancy;
   } rsp_type;

   // One heap slot.
   typedef struct packed {
      logic [PRIORITY_W-1:0] pri;
      logic [PAYLOAD_W-1:0]  pay;
   } entry_type;

   // Access from the sequencer to the heap store.
   typedef struct packed {
      logic                 wr_en;
      logic [IDX_W-1:0]     wr_addr;
      entry_type            wr_data;
      logic [IDX_W-1:0]     rd_addr0;
      logic [IDX_W-1:0]     rd_addr1;
   } mem_req_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RM_LOAD,
      ST_UP_READ,
      ST_UP_SWAP,
      ST_DN_READ,
      ST_DN_PICK,
      ST_DN_SWAP,
      ST_DONE
   } state_type;

endpackage

// File: sv/binary_max_heap_priority_queue.sv
// Top level of the binary max-heap priority queue.
//
// A request word on req_ carries a command (insert or remove), a priority and
// a payload. Each request yields exactly one response word on rsp_ with a
// status, the removed priority and payload (zero unless a remove succeeded)
// and the occupancy after the request. Both channels use valid and stall; a
// word moves when valid is high and stall is low.
// The csr_ write channel loads the capacity limit and is always ready. The
// user must write it only while the queue is idle; the block does not enforce
// this. Reset clears the queue to empty and sets the limit to 64.
// One request is worked at a time through one compare and one memory write
// per step. An insert climbs at most six tree levels, each a parent read
// (ST_UP_READ) then a compare and write (ST_UP_SWAP); a remove loads the root
// and last entry (ST_RM_LOAD), then descends at most five levels, each a
// child read, pick and compare-and-write. A full insert or an empty remove
// goes straight to ST_DONE. The response word is offered as req_stall falls.
// The response register lets the next request be taken while a response
// waits under rsp_stall; that request then finishes and holds until the
// response register drains.
module binary_max_heap_priority_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  hpq_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output hpq_pkg::rsp_type             rsp_data,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [hpq_pkg::CAP_W-1:0]    csr_data
);
   import hpq_pkg::*;

   logic [CAP_W-1:0] cap_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;
   logic             busy;
   logic             res_valid;
   logic             res_take;
   rsp_type          result;
   mem_req_type      mem_req;
   entry_type        rd_data0;
   entry_type        rd_data1;

   // Capacity register.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         cap_ff <= csr_data;
      end
   end
   assign csr_ready = 1'b1;

   // Response register loads when empty or draining.
   assign res_take     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = res_valid ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_take) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign req_stall = busy;

   hpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (req_valid && !busy),
      .item      (req_data),
      .cap_limit (cap_ff),
      .res_take  (res_take),
      .busy      (busy),
      .res_valid (res_valid),
      .result    (result),
      .mem_req   (mem_req),
      .rd_data0  (rd_data0),
      .rd_data1  (rd_data1)
   );

   hpq_store u_store (
      .clock    (clock),
      .mem_req  (mem_req),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

endmodule

// File: sv/hpq_store.sv
// Heap slot memory with one write port and two registered read ports.
module hpq_store (
   input  logic                 clock,
   input  hpq_pkg::mem_req_type mem_req,
   output hpq_pkg::entry_type   rd_data0,
   output hpq_pkg::entry_type   rd_data1
);
   import hpq_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd0_ff;
   entry_type rd1_ff;

   // Write the addressed slot and register both read ports.
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd0_ff <= mem[mem_req.rd_addr0];
      rd1_ff <= mem[mem_req.rd_addr1];
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule

// File: sv/hpq_ctrl.sv
// Sift sequencer with the single shared priority comparator.
module hpq_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  hpq_pkg::req_type        item,
   input  logic [hpq_pkg::CAP_W-1:0] cap_limit,
   input  logic                    res_take,
   output logic                    busy,
   output logic                    res_valid,
   output hpq_pkg::rsp_type        result,
   output hpq_pkg::mem_req_type    mem_req,
   input  hpq_pkg::entry_type      rd_data0,
   input  hpq_pkg::entry_type      rd_data1
);
   import hpq_pkg::*;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   entry_type              hold_ff, hold_in;
   entry_type              child_ff, child_in;
   logic [IDX_W-1:0]       child_idx_ff, child_idx_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   entry_type              out_ent_ff, out_ent_in;

   logic [CNT_W-1:0]       eff_limit;
   logic                   is_full;
   logic [IDX_W-1:0]       pos_m1;
   logic [IDX_W-1:0]       parent;
   logic [CHILD_W-1:0]     left_w;
   logic [CHILD_W-1:0]     right_w;
   logic                   left_ok;
   logic                   right_ok;
   logic [PRIORITY_W-1:0]  cmp_a;
   logic [PRIORITY_W-1:0]  cmp_b;
   logic                   cmp_gt;

   // Effective limit is the register clamped to the slot count.
   always_comb begin
      if (cap_limit > CAP_W'(DEPTH)) begin
         eff_limit = CNT_W'(DEPTH);
      end else begin
         eff_limit = CNT_W'(cap_limit);
      end
   end
   assign is_full = (count_ff >= eff_limit);

   // Tree index arithmetic around the current hole.
   assign pos_m1   = pos_ff - IDX_W'(1);
   assign parent   = {1'b0, pos_m1[IDX_W-1:1]};
   assign left_w   = {1'b0, pos_ff, 1'b1};
   assign right_w  = left_w + CHILD_W'(1);
   assign left_ok  = (left_w < CHILD_W'(count_ff));
   assign right_ok = (right_w < CHILD_W'(count_ff));

   // The one comparator; its operands follow the sequencer state.
   always_comb begin
      case (state_ff)
         ST_UP_SWAP: begin
            cmp_a = hold_ff.pri;
            cmp_b = rd_data0.pri;
         end
         ST_DN_PICK: begin
            cmp_a = rd_data1.pri;
            cmp_b = rd_data0.pri;
         end
         ST_DN_SWAP: begin
            cmp_a = child_ff.pri;
            cmp_b = hold_ff.pri;
         end
         default: begin
            cmp_a = hold_ff.pri;
            cmp_b = rd_data0.pri;
         end
      endcase
   end
   assign cmp_gt = (cmp_a > cmp_b);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (item.cmd == CMD_INSERT) begin
                  state_in = is_full ? ST_DONE : ST_UP_READ;
               end else begin
                  state_in = (count_ff == '0) ? ST_DONE : ST_RM_LOAD;
               end
            end
         end
         ST_RM_LOAD: state_in = ST_DN_READ;
         ST_UP_READ: state_in = (pos_ff == '0) ? ST_DONE : ST_UP_SWAP;
         ST_UP_SWAP: state_in = cmp_gt ? ST_UP_READ : ST_DONE;
         ST_DN_READ: state_in = left_ok ? ST_DN_PICK : ST_DONE;
         ST_DN_PICK: state_in = ST_DN_SWAP;
         ST_DN_SWAP: state_in = cmp_gt ? ST_DN_READ : ST_DONE;
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath updates and memory access for each state.
   always_comb begin
      pos_in           = pos_ff;
      count_in         = count_ff;
      hold_in          = hold_ff;
      child_in         = child_ff;
      child_idx_in     = child_idx_ff;
      status_in        = status_ff;
      out_ent_in       = out_ent_ff;
      mem_req.wr_en    = 1'b0;
      mem_req.wr_addr  = pos_ff;
      mem_req.wr_data  = hold_ff;
      mem_req.rd_addr0 = parent;
      mem_req.rd_addr1 = right_w[IDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               out_ent_in = '0;
               if (item.cmd == CMD_INSERT) begin
                  if (is_full) begin
                     status_in = STAT_FULL;
                  end else begin
                     status_in   = STAT_OK;
                     hold_in.pri = item.priority_req;
                     hold_in.pay = item.payload;
                     pos_in      = count_ff[IDX_W-1:0];
                     count_in    = count_ff + CNT_W'(1);
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STAT_EMPTY;
                  end else begin
                     // Fetch the root and the last entry together.
                     status_in        = STAT_OK;
                     count_in         = count_ff - CNT_W'(1);
                     mem_req.rd_addr0 = '0;
                     mem_req.rd_addr1 = pos_m1;
                  end
               end
               if (item.cmd == CMD_REMOVE && count_ff != '0) begin
                  mem_req.rd_addr1 = CNT_W'(count_ff - CNT_W'(1)) >= CNT_W'(DEPTH) ?
                                     '0 : IDX_W'(count_ff - CNT_W'(1));
               end
            end
         end
         ST_RM_LOAD: begin
            out_ent_in = rd_data0;
            hold_in    = rd_data1;
            pos_in     = '0;
         end
         ST_UP_READ: begin
            // At the root the moving entry settles.
            if (pos_ff == '0) begin
               mem_req.wr_en = 1'b1;
            end
            mem_req.rd_addr0 = parent;
         end
         ST_UP_SWAP: begin
            mem_req.wr_en = 1'b1;
            if (cmp_gt) begin
               mem_req.wr_data = rd_data0;
               pos_in          = parent;
            end
         end
         ST_DN_READ: begin
            if (!left_ok) begin
               mem_req.wr_en = 1'b1;
            end
            mem_req.rd_addr0 = left_w[IDX_W-1:0];
            mem_req.rd_addr1 = right_w[IDX_W-1:0];
         end
         ST_DN_PICK: begin
            // Right child wins only when present and strictly greater.
            if (right_ok && cmp_gt) begin
               child_in     = rd_data1;
               child_idx_in = right_w[IDX_W-1:0];
            end else begin
               child_in     = rd_data0;
               child_idx_in = left_w[IDX_W-1:0];
            end
         end
         ST_DN_SWAP: begin
            mem_req.wr_en = 1'b1;
            if (cmp_gt) begin
               mem_req.wr_data = child_ff;
               pos_in          = child_idx_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      hold_ff      <= hold_in;
      child_ff     <= child_in;
      child_idx_ff <= child_idx_in;
      status_ff    <= status_in;
      out_ent_ff   <= out_ent_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign res_valid           = (state_ff == ST_DONE);
   assign result.status       = status_ff;
   assign result.out_priority = out_ent_ff.pri;
   assign result.out_payload  = out_ent_ff.pay;
   assign result.occupancy    = OCC_W'(count_ff);

endmodule
